>>> hw/rtl/tilt_angle_kalman_filter_defines.svh
// Assertion macros for the tilt angle filter.
`ifndef TILT_ANGLE_KALMAN_FILTER_DEFINES_SVH
`define TILT_ANGLE_KALMAN_FILTER_DEFINES_SVH
`ifndef SYNTH
`define TAKF_ASSERT_IMPL(label, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("takf check failed");
`define TAKF_ASSERT_NEXT(label, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("takf check failed");
`else
`define TAKF_ASSERT_IMPL(label, a, c)
`define TAKF_ASSERT_NEXT(label, a, c)
`endif
`endif

>>> hw/rtl/takf_pkg.sv
package takf_pkg;

    localparam int NUM_AXES = 2;
    localparam int REG_W = 31;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_QA = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_QB = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_R  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DT = 2'd3;

    localparam logic [REG_W-1:0] QA_RESET = 31'd1073742;
    localparam logic [REG_W-1:0] QB_RESET = 31'd3221225;
    localparam logic [REG_W-1:0] R_RESET  = 31'd536870912;
    localparam logic [REG_W-1:0] DT_RESET = 31'd2147484;

    localparam logic signed [31:0] Q30_ONE = 32'sd1073741824;

    // Saturate a 34-bit signed sum to 32 bits.
    function automatic logic signed [31:0] sat34(input logic signed [33:0] v);
        logic signed [31:0] r;
        if (v > 34'sd2147483647)
            r = 32'sh7FFFFFFF;
        else if (v < -34'sd2147483648)
            r = 32'sh80000000;
        else
            r = v[31:0];
        return r;
    endfunction

    // Saturate a 64-bit signed value to 32 bits.
    function automatic logic signed [31:0] sat64(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sd2147483647)
            r = 32'sh7FFFFFFF;
        else if (v < -64'sd2147483648)
            r = 32'sh80000000;
        else
            r = v[31:0];
        return r;
    endfunction

endpackage

>>> hw/rtl/takf_div.sv
// Restoring divider: 62-bit magnitude numerator over 32-bit positive
// divisor, one quotient bit per cycle, result saturated to signed 32 bits.
module takf_div (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic signed [31:0] num,
    input  logic [31:0]        den,
    output logic               done,
    output logic signed [31:0] quo
);

    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        neg_reg, neg_next;
    logic [61:0] n_reg, n_next;
    logic [32:0] rem_reg, rem_next;
    logic [31:0] den_reg, den_next;
    logic [61:0] q_reg, q_next;
    logic        done_reg, done_next;
    logic [32:0] trial;
    logic [31:0] mag;
    logic signed [63:0] sq;

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        neg_next  = neg_reg;
        n_next    = n_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        q_next    = q_reg;
        done_next = 1'b0;
        mag       = num[31] ? 32'(-num) : 32'(num);
        trial     = {rem_reg[31:0], n_reg[61]};
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = 6'd0;
            neg_next  = num[31];
            n_next    = {mag, 30'd0};
            rem_next  = '0;
            den_next  = den;
            q_next    = '0;
        end
        else if (busy_reg)
        begin
            n_next = {n_reg[60:0], 1'b0};
            if (trial >= {1'b0, den_reg})
            begin
                rem_next = trial - {1'b0, den_reg};
                q_next   = {q_reg[60:0], 1'b1};
            end
            else
            begin
                rem_next = trial;
                q_next   = {q_reg[60:0], 1'b0};
            end
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == 6'd61)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg <= neg_next;
        n_reg   <= n_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
        q_reg   <= q_next;
    end

    assign sq   = neg_reg ? -$signed({2'b00, q_reg}) : $signed({2'b00, q_reg});
    assign done = done_reg;
    assign quo  = takf_pkg::sat64(sq);

endmodule

>>> hw/rtl/tilt_angle_kalman_filter.sv
// Two-state angle and gyro bias Kalman filter, one filter per axis.
// Input channel s_axis_*: tdata carries accel_angle and gyro_rate, tuser the
// axis. Output channel m_axis_*: tdata carries filtered_angle and
// corrected_rate, tuser the axis the result belongs to.
// The configuration port writes Q, bias Q, R and the sample period, each
// unsigned Q1.30; write only while the block is idle.
// Each item runs a short sequence of 32x32 products on one shared multiplier,
// plus two passes of a bit-serial divider that forms the two gains.
// When the innovation variance is not positive the divisions are skipped.
// s_axis_tready is low while an item is at work. The result sits in an output
// register; the block takes the next item as soon as its own sequence ends,
// even while that result still waits, but it does not finish another item
// until the waiting result has been taken.
// Reset puts every axis at angle and bias zero with unit covariance on the
// diagonal, and restores the default register values.
// Each product of a Q2.30 value is rounded half up and every sum saturates.
`include "tilt_angle_kalman_filter_defines.svh"
module tilt_angle_kalman_filter (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [takf_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [takf_pkg::REG_W-1:0]     cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // accel_angle [31:0], gyro_rate [63:32]
    input  logic        s_axis_tuser,   // axis
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // filtered_angle [31:0], corrected_rate [63:32]
    output logic        m_axis_tuser    // axis_out
);

    localparam logic [4:0] ST_IDLE = 5'd0;
    localparam logic [4:0] ST_M1   = 5'd1;   // rate*dt
    localparam logic [4:0] ST_M2   = 5'd2;   // d00*dt
    localparam logic [4:0] ST_M3   = 5'd3;   // d01*dt
    localparam logic [4:0] ST_M4   = 5'd4;   // Qb*dt
    localparam logic [4:0] ST_PRED = 5'd5;
    localparam logic [4:0] ST_D0   = 5'd6;
    localparam logic [4:0] ST_D0W  = 5'd7;
    localparam logic [4:0] ST_D1W  = 5'd8;
    localparam logic [4:0] ST_U1   = 5'd9;   // K0*t0
    localparam logic [4:0] ST_U2   = 5'd10;  // K0*t1
    localparam logic [4:0] ST_U3   = 5'd11;  // K1*t0
    localparam logic [4:0] ST_U4   = 5'd12;  // K1*t1
    localparam logic [4:0] ST_U5   = 5'd13;  // K0*err
    localparam logic [4:0] ST_U6   = 5'd14;  // K1*err
    localparam logic [4:0] ST_OUT  = 5'd15;

    logic [takf_pkg::REG_W-1:0] qa_reg, qb_reg, r_reg, dt_reg;

    logic signed [31:0] ang_mem [takf_pkg::NUM_AXES];
    logic signed [31:0] bias_mem [takf_pkg::NUM_AXES];
    logic signed [31:0] p00_mem [takf_pkg::NUM_AXES];
    logic signed [31:0] p01_mem [takf_pkg::NUM_AXES];
    logic signed [31:0] p10_mem [takf_pkg::NUM_AXES];
    logic signed [31:0] p11_mem [takf_pkg::NUM_AXES];

    logic [4:0] state_reg;
    logic       ax_reg;
    logic signed [31:0] accel_reg, gyro_reg;
    logic signed [31:0] rate_reg, ang_reg, bias_reg, err_reg;
    logic signed [31:0] p00_reg, p01_reg, p10_reg, p11_reg, t0_reg, t1_reg;
    logic signed [31:0] k0_reg, k1_reg;
    logic signed [31:0] ma, mb;
    logic signed [63:0] prod;
    // A rounded product can reach 2^32 in magnitude, so it keeps 34 bits.
    logic signed [33:0] rnd;
    logic signed [33:0] e_sum;
    logic               e_pos_reg;

    logic        ovalid_reg;
    logic [63:0] odata_reg;
    logic        ouser_reg;

    logic               div_start;
    logic signed [31:0] div_num;
    logic               div_done;
    logic signed [31:0] div_quo;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tdata  = odata_reg;
    assign m_axis_tuser  = ouser_reg;

    // Shared multiplier operand selection.
    always_comb
    begin
        unique case (state_reg)
            ST_M1:   begin ma = rate_reg; mb = $signed({1'b0, dt_reg}); end
            ST_M2:   begin ma = t0_reg;   mb = $signed({1'b0, dt_reg}); end
            ST_M3:   begin ma = t1_reg;   mb = $signed({1'b0, dt_reg}); end
            ST_M4:   begin ma = $signed({1'b0, qb_reg}); mb = $signed({1'b0, dt_reg}); end
            ST_U1:   begin ma = k0_reg; mb = t0_reg; end
            ST_U2:   begin ma = k0_reg; mb = t1_reg; end
            ST_U3:   begin ma = k1_reg; mb = t0_reg; end
            ST_U4:   begin ma = k1_reg; mb = t1_reg; end
            ST_U5:   begin ma = k0_reg; mb = err_reg; end
            ST_U6:   begin ma = k1_reg; mb = err_reg; end
            default: begin ma = '0; mb = '0; end
        endcase
    end

    assign prod  = ma * mb;
    assign rnd   = 34'((prod + 64'sd536870912) >>> 30);
    assign e_sum = $signed({3'b000, r_reg}) + 34'(p00_reg);

    assign div_start = (state_reg == ST_PRED && e_pos_reg) || (state_reg == ST_D0W && div_done);
    assign div_num   = (state_reg == ST_PRED) ? p00_reg : p10_reg;

    takf_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (e_sum[31:0]),
        .done  (div_done),
        .quo   (div_quo)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            qa_reg <= takf_pkg::QA_RESET;
            qb_reg <= takf_pkg::QB_RESET;
            r_reg  <= takf_pkg::R_RESET;
            dt_reg <= takf_pkg::DT_RESET;
            state_reg  <= ST_IDLE;
            ovalid_reg <= 1'b0;
            for (int i = 0; i < takf_pkg::NUM_AXES; i++)
            begin
                ang_mem[i]  <= '0;
                bias_mem[i] <= '0;
                p00_mem[i]  <= takf_pkg::Q30_ONE;
                p01_mem[i]  <= '0;
                p10_mem[i]  <= '0;
                p11_mem[i]  <= takf_pkg::Q30_ONE;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    takf_pkg::CFG_QA: qa_reg <= cfg_data;
                    takf_pkg::CFG_QB: qb_reg <= cfg_data;
                    takf_pkg::CFG_R:  r_reg  <= cfg_data;
                    takf_pkg::CFG_DT: dt_reg <= cfg_data;
                    default: ;
                endcase
            end
            // In ST_OUT the handover below decides the valid flag itself.
            if (ovalid_reg && m_axis_tready && state_reg != ST_OUT)
                ovalid_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (s_axis_tvalid)
                    begin
                        ax_reg    <= s_axis_tuser;
                        accel_reg <= s_axis_tdata[31:0];
                        gyro_reg  <= s_axis_tdata[63:32];
                        rate_reg  <= takf_pkg::sat34(34'($signed(s_axis_tdata[63:32]))
                                     - 34'(bias_mem[s_axis_tuser]));
                        ang_reg   <= ang_mem[s_axis_tuser];
                        bias_reg  <= bias_mem[s_axis_tuser];
                        p00_reg   <= p00_mem[s_axis_tuser];
                        p01_reg   <= p01_mem[s_axis_tuser];
                        p10_reg   <= p10_mem[s_axis_tuser];
                        p11_reg   <= p11_mem[s_axis_tuser];
                        // t0 holds d00, t1 holds d01 during the prediction.
                        t0_reg <= takf_pkg::sat34($signed({3'b000, qa_reg})
                                  - 34'(p01_mem[s_axis_tuser]) - 34'(p10_mem[s_axis_tuser]));
                        t1_reg <= takf_pkg::sat34(-34'(p11_mem[s_axis_tuser]));
                        state_reg <= ST_M1;
                    end
                end
                ST_M1:
                begin
                    ang_reg   <= takf_pkg::sat34(34'(ang_reg) + rnd);
                    state_reg <= ST_M2;
                end
                ST_M2:
                begin
                    p00_reg   <= takf_pkg::sat34(34'(p00_reg) + rnd);
                    state_reg <= ST_M3;
                end
                ST_M3:
                begin
                    p01_reg   <= takf_pkg::sat34(34'(p01_reg) + rnd);
                    p10_reg   <= takf_pkg::sat34(34'(p10_reg) + rnd);
                    state_reg <= ST_M4;
                end
                ST_M4:
                begin
                    p11_reg   <= takf_pkg::sat34(34'(p11_reg) + rnd);
                    err_reg   <= takf_pkg::sat34(34'(accel_reg) - 34'(ang_reg));
                    state_reg <= ST_D0;
                end
                ST_D0:
                begin
                    e_pos_reg <= (e_sum > 34'sd0);
                    state_reg <= ST_PRED;
                end
                ST_PRED:
                begin
                    t0_reg <= p00_reg;
                    t1_reg <= p01_reg;
                    if (e_pos_reg)
                        state_reg <= ST_D0W;
                    else
                    begin
                        k0_reg    <= '0;
                        k1_reg    <= '0;
                        state_reg <= ST_U1;
                    end
                end
                ST_D0W:
                begin
                    if (div_done)
                    begin
                        k0_reg    <= div_quo;
                        state_reg <= ST_D1W;
                    end
                end
                ST_D1W:
                begin
                    if (div_done)
                    begin
                        k1_reg    <= div_quo;
                        state_reg <= ST_U1;
                    end
                end
                ST_U1:
                begin
                    p00_reg   <= takf_pkg::sat34(34'(p00_reg) - rnd);
                    state_reg <= ST_U2;
                end
                ST_U2:
                begin
                    p01_reg   <= takf_pkg::sat34(34'(p01_reg) - rnd);
                    state_reg <= ST_U3;
                end
                ST_U3:
                begin
                    p10_reg   <= takf_pkg::sat34(34'(p10_reg) - rnd);
                    state_reg <= ST_U4;
                end
                ST_U4:
                begin
                    p11_reg   <= takf_pkg::sat34(34'(p11_reg) - rnd);
                    state_reg <= ST_U5;
                end
                ST_U5:
                begin
                    ang_reg   <= takf_pkg::sat34(34'(ang_reg) + rnd);
                    state_reg <= ST_U6;
                end
                ST_U6:
                begin
                    bias_reg  <= takf_pkg::sat34(34'(bias_reg) + rnd);
                    state_reg <= ST_OUT;
                end
                ST_OUT:
                begin
                    if (!ovalid_reg || m_axis_tready)
                    begin
                        ang_mem[ax_reg]  <= ang_reg;
                        bias_mem[ax_reg] <= bias_reg;
                        p00_mem[ax_reg]  <= p00_reg;
                        p01_mem[ax_reg]  <= p01_reg;
                        p10_mem[ax_reg]  <= p10_reg;
                        p11_mem[ax_reg]  <= p11_reg;
                        ovalid_reg <= 1'b1;
                        ouser_reg  <= ax_reg;
                        odata_reg  <= {takf_pkg::sat34(34'(gyro_reg) - 34'(bias_reg)),
                                       ang_reg};
                        state_reg  <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    `TAKF_ASSERT_IMPL(a_no_accept_busy, state_reg != ST_IDLE, !s_axis_tready)
    `TAKF_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
    `TAKF_ASSERT_IMPL(a_div_only_waiting, div_done, state_reg == ST_D0W || state_reg == ST_D1W)

endmodule

>>> dv/testbench.sv
`timescale 1ns / 1ps

// The testbench streams tilt samples into the filter on both axes and keeps its own copy
// of the per-axis angle, bias and covariance. From these it computes each expected filtered
// angle and corrected rate. Results are checked in order against a queue of pending
// expectations. The registers are rewritten between phases, only while the filter is idle.
module testbench;

    typedef struct packed {
        logic              axis;
        logic signed [31:0] accel;
        logic signed [31:0] gyro;
    } sample_t;

    typedef struct packed {
        logic              axis;
        logic signed [31:0] angle;
        logic signed [31:0] rate;
    } estimate_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [takf_pkg::CFG_IDX_W-1:0] cfg_index = takf_pkg::CFG_QA;
    logic [takf_pkg::REG_W-1:0]     cfg_data = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata = '0;
    logic        s_axis_tuser = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [63:0] m_axis_tdata;
    logic        m_axis_tuser;

    tilt_angle_kalman_filter uut (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // The filter state that the predictor keeps, one entry for each axis.
    logic signed [31:0] est_angle [takf_pkg::NUM_AXES];
    logic signed [31:0] est_bias [takf_pkg::NUM_AXES];
    logic signed [31:0] cov00 [takf_pkg::NUM_AXES];
    logic signed [31:0] cov01 [takf_pkg::NUM_AXES];
    logic signed [31:0] cov10 [takf_pkg::NUM_AXES];
    logic signed [31:0] cov11 [takf_pkg::NUM_AXES];
    logic signed [63:0] noise_angle, noise_bias, noise_meas, step_dt;

    sample_t   pending_samples [$];
    estimate_t expected_estimates [$];
    int        errors = 0;
    longint    cycles = 0;
    bit        calm = 1'b0;     // While set, neither side idles.

    function automatic logic signed [31:0] clamp32(input logic signed [63:0] v);
        if (v > 64'sd2147483647)
            return 32'sh7FFFFFFF;
        if (v < -64'sd2147483648)
            return 32'sh80000000;
        return v[31:0];
    endfunction

    // The product of a Q2.30 factor, rounded half up: add 2^29, then shift right
    // by 30 with floor. An arithmetic shift gives the floor.
    function automatic logic signed [63:0] scale_q30(input logic signed [63:0] a,
                                                      input logic signed [63:0] b);
        logic signed [63:0] p;
        p = a * b + 64'sd536870912;
        return p >>> 30;
    endfunction

    // Runs one predict and update step on the stored state and returns the expected result.
    function automatic estimate_t kalman_update(input sample_t smp);
        estimate_t res;
        int a;
        logic signed [63:0] rate, d00, d01, e, k0, k1, t0, t1, err;
        logic signed [31:0] p00, p01, p10, p11, ang, bias;
        a = int'(smp.axis);
        p00 = cov00[a];
        p01 = cov01[a];
        p10 = cov10[a];
        p11 = cov11[a];
        rate = 64'(clamp32(64'(smp.gyro) - 64'(est_bias[a])));
        ang = clamp32(64'(est_angle[a]) + scale_q30(rate, step_dt));
        d00 = 64'(clamp32(noise_angle - 64'(p01) - 64'(p10)));
        d01 = 64'(clamp32(-64'(p11)));
        p00 = clamp32(64'(p00) + scale_q30(d00, step_dt));
        p01 = clamp32(64'(p01) + scale_q30(d01, step_dt));
        p10 = clamp32(64'(p10) + scale_q30(d01, step_dt));
        p11 = clamp32(64'(p11) + scale_q30(noise_bias, step_dt));
        err = 64'(clamp32(64'(smp.accel) - 64'(ang)));
        e = noise_meas + 64'(p00);
        // A non-positive innovation variance gives zero gains.
        if (e > 0)
        begin
            k0 = 64'(clamp32((64'(p00) * 64'sd1073741824) / e));
            k1 = 64'(clamp32((64'(p10) * 64'sd1073741824) / e));
        end
        else
        begin
            k0 = 64'sd0;
            k1 = 64'sd0;
        end
        t0 = 64'(p00);
        t1 = 64'(p01);
        p00 = clamp32(64'(p00) - scale_q30(k0, t0));
        p01 = clamp32(64'(p01) - scale_q30(k0, t1));
        p10 = clamp32(64'(p10) - scale_q30(k1, t0));
        p11 = clamp32(64'(p11) - scale_q30(k1, t1));
        ang = clamp32(64'(ang) + scale_q30(k0, err));
        bias = clamp32(64'(est_bias[a]) + scale_q30(k1, err));
        est_angle[a] = ang;
        est_bias[a] = bias;
        cov00[a] = p00;
        cov01[a] = p01;
        cov10[a] = p10;
        cov11[a] = p11;
        res.axis = smp.axis;
        res.angle = ang;
        res.rate = clamp32(64'(smp.gyro) - 64'(bias));
        return res;
    endfunction

    // The driver presents the pending items in order and idles at random between them.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                expected_estimates.push_back(kalman_update(pending_samples.pop_front()));
            end
            if ((!s_axis_tvalid || s_axis_tready) && !calm && $urandom_range(99) < 37)
                s_axis_tvalid <= 1'b0;
            else if (pending_samples.size() > 0 &&
                     !(s_axis_tvalid && s_axis_tready && pending_samples.size() == 0))
            begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata <= {pending_samples[0].gyro, pending_samples[0].accel};
                s_axis_tuser <= pending_samples[0].axis;
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    // The monitor stalls at random, and checks each accepted result against the oldest
    // expectation.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_estimates.size() == 0)
                begin
                    $display("%0t: unexpected result axis %0d tdata %h", $time,
                             m_axis_tuser, m_axis_tdata);
                    errors++;
                end
                else
                begin
                    estimate_t exp_est;
                    exp_est = expected_estimates.pop_front();
                    if (m_axis_tuser !== exp_est.axis)
                    begin
                        $display("%0t: axis expected %0d actual %0d", $time,
                                 exp_est.axis, m_axis_tuser);
                        errors++;
                    end
                    if (m_axis_tdata[31:0] !== exp_est.angle)
                    begin
                        $display("%0t: filtered_angle expected %h actual %h", $time,
                                 exp_est.angle, m_axis_tdata[31:0]);
                        errors++;
                    end
                    if (m_axis_tdata[63:32] !== exp_est.rate)
                    begin
                        $display("%0t: corrected_rate expected %h actual %h", $time,
                                 exp_est.rate, m_axis_tdata[63:32]);
                        errors++;
                    end
                end
            end
            m_axis_tready <= calm || ($urandom_range(99) >= 37);
        end
    end

    // Bounds the run.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > 1000000)
        begin
            $display("testbench NOT OK");
            $finish;
        end
    end

    task automatic push_sample(input logic ax, input logic [31:0] acc, input logic [31:0] gy);
        sample_t s;
        s.axis = ax;
        s.accel = acc;
        s.gyro = gy;
        pending_samples.push_back(s);
    endtask

    function automatic logic [31:0] rand_word();
        case ($urandom_range(3))
            0: return $urandom();
            1: return $urandom_range(32'h0020_0000) - 32'h0010_0000;
            2: return {{16{1'b0}}, 16'($urandom())} - 32'h0000_8000;
            default: return $urandom_range(32'h00B4_0000) - 32'h005A_0000;
        endcase
    endfunction

    // Waits until everything is sent and checked, then lets the filter settle.
    task automatic drain();
        wait (pending_samples.size() == 0 && expected_estimates.size() == 0);
        repeat (200) @(posedge clk);
    endtask

    // Writes a register while the filter is idle, and updates the predictor to match.
    task automatic write_register(input logic [takf_pkg::CFG_IDX_W-1:0] idx,
                                  input logic [takf_pkg::REG_W-1:0] value);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            takf_pkg::CFG_QA: noise_angle = 64'(value);
            takf_pkg::CFG_QB: noise_bias = 64'(value);
            takf_pkg::CFG_R:  noise_meas = 64'(value);
            default: step_dt = 64'(value);
        endcase
    endtask

    task automatic random_phase(input int count);
        // Mostly slowly drifting tracks, so that the filter converges; some noise.
        logic signed [31:0] track;
        track = 0;
        repeat (count)
        begin
            if ($urandom_range(9) < 7)
            begin
                track = track + 32'($urandom_range(4096)) - 32'sd2048;
                push_sample(1'($urandom_range(1)), track + 32'($urandom_range(1024)) - 512,
                            32'($urandom_range(65536 * 20)) - 32'sd655360);
            end
            else
                push_sample(1'($urandom_range(1)), rand_word(), rand_word());
        end
    endtask

    initial
    begin
        for (int a = 0; a < takf_pkg::NUM_AXES; a++)
        begin
            est_angle[a] = 0;
            est_bias[a] = 0;
            cov00[a] = takf_pkg::Q30_ONE;
            cov01[a] = 0;
            cov10[a] = 0;
            cov11[a] = takf_pkg::Q30_ONE;
        end
        noise_angle = 64'(takf_pkg::QA_RESET);
        noise_bias = 64'(takf_pkg::QB_RESET);
        noise_meas = 64'(takf_pkg::R_RESET);
        step_dt = 64'(takf_pkg::DT_RESET);
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: the extremes of both fields on both axes, plus ordinary values.
        push_sample(1'b0, 32'h7FFF_FFFF, 32'h8000_0000);
        push_sample(1'b1, 32'h8000_0000, 32'h7FFF_FFFF);
        push_sample(1'b0, 32'h8000_0000, 32'h8000_0000);
        push_sample(1'b1, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        push_sample(1'b0, 32'h0, 32'h0);
        push_sample(1'b1, 32'hFFFF_FFFF, 32'h1);
        push_sample(1'b0, 32'h000A_0000, 32'h0001_0000);
        push_sample(1'b1, 32'hFFF6_0000, 32'hFFFF_0000);
        drain();

        // A zero sample period leaves the prediction as it is.
        write_register(takf_pkg::CFG_DT, 31'd0);
        push_sample(1'b0, 32'h0005_0000, 32'h0003_0000);
        push_sample(1'b1, 32'hFFFB_0000, 32'h7FFF_FFFF);
        drain();

        // Zero measurement noise; then the largest value in every register.
        write_register(takf_pkg::CFG_R, 31'd0);
        write_register(takf_pkg::CFG_DT, 31'h7FFF_FFFF);
        push_sample(1'b0, 32'h0001_0000, 32'h0002_0000);
        push_sample(1'b1, 32'h8000_0000, 32'h0);
        drain();
        write_register(takf_pkg::CFG_QA, 31'h7FFF_FFFF);
        write_register(takf_pkg::CFG_QB, 31'h7FFF_FFFF);
        write_register(takf_pkg::CFG_R, 31'h7FFF_FFFF);
        push_sample(1'b0, 32'h1234_5678, 32'h8765_4321);
        push_sample(1'b1, 32'h7FFF_0000, 32'h8000_0001);
        push_sample(1'b0, 32'hFFFF_0000, 32'h0000_FFFF);
        drain();

        // Settings with the smallest values: Q at zero, R and the period at one.
        write_register(takf_pkg::CFG_QA, 31'd0);
        write_register(takf_pkg::CFG_QB, 31'd0);
        write_register(takf_pkg::CFG_R, 31'd1);
        write_register(takf_pkg::CFG_DT, 31'd1);
        push_sample(1'b0, 32'h0003_0000, 32'h0001_0000);
        push_sample(1'b1, 32'hFFFD_0000, 32'hFFFF_0000);
        drain();

        // Back to the defaults for a long random phase with no idling at first.
        write_register(takf_pkg::CFG_QA, takf_pkg::QA_RESET);
        write_register(takf_pkg::CFG_QB, takf_pkg::QB_RESET);
        write_register(takf_pkg::CFG_R, takf_pkg::R_RESET);
        write_register(takf_pkg::CFG_DT, takf_pkg::DT_RESET);
        calm = 1'b1;
        random_phase(150);
        wait (pending_samples.size() == 0);
        calm = 1'b0;
        random_phase(350);
        drain();

        // Random settings, then a random phase for each.
        repeat (3)
        begin
            write_register(takf_pkg::CFG_QA, 31'($urandom_range(31'h0100_0000)));
            write_register(takf_pkg::CFG_QB, 31'($urandom_range(31'h0100_0000)));
            write_register(takf_pkg::CFG_R, 31'($urandom_range(31'h7FFF_FFFF, 1)));
            write_register(takf_pkg::CFG_DT, 31'($urandom_range(31'h0400_0000, 1)));
            random_phase(170);
            drain();
        end

        if (errors == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end
endmodule
